FILE: rtl/core/rvdi_pkg.sv
`default_nettype none

package rvdi_pkg;

   localparam logic [6:0] OP_RTYPE  = 7'h33;
   localparam logic [6:0] OP_ALUIMM = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_FENCE  = 7'h0F;
   localparam logic [6:0] OP_ZERO   = 7'h00;

   localparam logic [11:0] F12_ECALL  = 12'h000;
   localparam logic [11:0] F12_EBREAK = 12'h001;
   localparam logic [11:0] F12_MRET   = 12'h302;
   localparam logic [11:0] F12_WFI    = 12'h105;

   localparam logic [2:0] F3_PRIV     = 3'd0;
   localparam logic [2:0] F3_RESERVED = 3'd4;
   localparam logic [2:0] F3_CSRRC    = 3'd3;

   localparam logic [4:0] KIND_RTYPE   = 5'd0;
   localparam logic [4:0] KIND_ALUIMM  = 5'd1;
   localparam logic [4:0] KIND_LOAD    = 5'd2;
   localparam logic [4:0] KIND_STORE   = 5'd3;
   localparam logic [4:0] KIND_BRANCH  = 5'd4;
   localparam logic [4:0] KIND_LUI     = 5'd5;
   localparam logic [4:0] KIND_AUIPC   = 5'd6;
   localparam logic [4:0] KIND_JAL     = 5'd7;
   localparam logic [4:0] KIND_JALR    = 5'd8;
   localparam logic [4:0] KIND_ECALL   = 5'd9;
   localparam logic [4:0] KIND_MRET    = 5'd10;
   localparam logic [4:0] KIND_CSR     = 5'd11;
   localparam logic [4:0] KIND_EBREAK  = 5'd12;
   localparam logic [4:0] KIND_WFI     = 5'd13;
   localparam logic [4:0] KIND_FENCE   = 5'd14;
   localparam logic [4:0] KIND_ILLEGAL = 5'd15;
   localparam logic [4:0] KIND_ZERO    = 5'd16;

   localparam logic [1:0] ACT_STALL  = 2'd0;
   localparam logic [1:0] ACT_SINGLE = 2'd1;
   localparam logic [1:0] ACT_DUAL   = 2'd2;

   typedef struct packed {
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  func3;
      logic [31:0] imm;
      logic [4:0]  kind;
      logic        use1;
      logic        use2;
      logic        wr;
      logic        mem;
      logic        ctl;
   } dec_type;

   function automatic dec_type decode_word(input logic [31:0] w);
      dec_type    d;
      logic [11:0] f12;
      f12     = w[31:20];
      d.rd    = w[11:7];
      d.rs1   = w[19:15];
      d.rs2   = w[24:20];
      d.func3 = w[14:12];
      d.imm   = '0;
      d.kind  = KIND_ILLEGAL;
      d.use1  = 1'b0;
      d.use2  = 1'b0;
      d.wr    = 1'b0;
      d.mem   = 1'b0;
      d.ctl   = 1'b0;
      case (w[6:0])
         OP_RTYPE: begin
            d.kind = KIND_RTYPE; d.use1 = 1'b1; d.use2 = 1'b1; d.wr = 1'b1;
         end
         OP_ALUIMM: begin
            d.kind = KIND_ALUIMM; d.use1 = 1'b1; d.wr = 1'b1;
            d.imm  = {{20{w[31]}}, w[31:20]};
         end
         OP_LOAD: begin
            d.kind = KIND_LOAD; d.use1 = 1'b1; d.wr = 1'b1; d.mem = 1'b1;
            d.imm  = {{20{w[31]}}, w[31:20]};
         end
         OP_STORE: begin
            d.kind = KIND_STORE; d.use1 = 1'b1; d.use2 = 1'b1; d.mem = 1'b1;
            d.imm  = {{20{w[31]}}, w[31:25], w[11:7]};
         end
         OP_BRANCH: begin
            d.kind = KIND_BRANCH; d.use1 = 1'b1; d.use2 = 1'b1; d.ctl = 1'b1;
            d.imm  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
         end
         OP_LUI: begin
            d.kind = KIND_LUI; d.wr = 1'b1; d.imm = {w[31:12], 12'h000};
         end
         OP_AUIPC: begin
            d.kind = KIND_AUIPC; d.wr = 1'b1; d.imm = {w[31:12], 12'h000};
         end
         OP_JAL: begin
            d.kind = KIND_JAL; d.wr = 1'b1; d.ctl = 1'b1;
            d.imm  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         OP_JALR: begin
            d.kind = KIND_JALR; d.use1 = 1'b1; d.wr = 1'b1; d.ctl = 1'b1;
            d.imm  = {{20{w[31]}}, w[31:20]};
         end
         OP_SYSTEM: begin
            if (d.func3 == F3_PRIV) begin
               case (f12)
                  F12_ECALL:  begin d.kind = KIND_ECALL; d.ctl = 1'b1; end
                  F12_MRET:   begin d.kind = KIND_MRET;  d.ctl = 1'b1; end
                  F12_EBREAK: d.kind = KIND_EBREAK;
                  F12_WFI:    d.kind = KIND_WFI;
                  default:    d.kind = KIND_ILLEGAL;
               endcase
            end else if (d.func3 == F3_RESERVED) begin
               d.kind = KIND_ILLEGAL;
            end else begin
               // csr ops: zimm forms read no register
               d.kind = KIND_CSR; d.ctl = 1'b1;
               d.imm  = {20'h00000, f12};
               d.wr   = (d.rd != 5'd0);
               d.use1 = (d.func3 <= F3_CSRRC);
            end
         end
         OP_FENCE: d.kind = KIND_FENCE;
         OP_ZERO:  d.kind = KIND_ZERO;
         default:  d.kind = KIND_ILLEGAL;
      endcase
      return d;
   endfunction

   function automatic logic reads_reg(input dec_type d, input logic [4:0] r);
      return (d.use1 && d.rs1 == r) || (d.use2 && d.rs2 == r);
   endfunction

   function automatic logic pairable(input dec_type a, input dec_type b);
      logic ok;
      ok = 1'b1;
      if (a.mem && b.mem) ok = 1'b0;
      if (a.ctl || b.ctl) ok = 1'b0;
      if (a.mem && a.wr && a.rd != 5'd0 && reads_reg(b, a.rd)) ok = 1'b0;
      return ok;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rv32i_dual_issue_decode.sv
`default_nettype none
// Words pass decode, hazard/pair check and output hold in turn. Throughput:
// one request word per cycle while the stages are not all full; rsp_ sends
// one result word per cycle while rsp_ready is high, a dual issue pair as two.
// Stages: decode, hazard/pair check, output hold; valid bits move with data.
// Reset (synchronous, active high) empties all stages; no results pending.

module rv32i_dual_issue_decode
   import rvdi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_slot0_valid,
   input  wire logic [31:0]        req_slot0_word,
   input  wire logic               req_slot1_valid,
   input  wire logic [31:0]        req_slot1_word,
   input  wire logic [4:0]         req_ex_load_dest0,
   input  wire logic [4:0]         req_ex_load_dest1,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_action,
   output logic                    rsp_lane,
   output logic [4:0]              rsp_dest_reg,
   output logic [4:0]              rsp_src1_reg,
   output logic [4:0]              rsp_src2_reg,
   output logic signed [31:0]      rsp_immediate,
   output logic [2:0]              rsp_func3,
   output logic                    rsp_writes_reg,
   output logic                    rsp_mem_read,
   output logic                    rsp_mem_write,
   output logic [4:0]              rsp_kind,
   output logic                    rsp_last
);

   // stage 1: decode
   logic       s1_vld_ff, s1_vld_in;
   dec_type    s1_d0_ff, s1_d1_ff;
   logic       s1_v1_ff;
   logic [4:0] s1_ld0_ff, s1_ld1_ff;
   // stage 2: hazard and pairing
   logic       s2_vld_ff, s2_vld_in;
   dec_type    s2_d0_ff, s2_d1_ff;
   logic       s2_stall_ff, s2_stall_in;
   logic       s2_dual_ff, s2_dual_in;
   // stage 3: output hold
   logic       s3_vld_ff, s3_vld_in;
   dec_type    s3_d0_ff, s3_d1_ff;
   logic       s3_stall_ff, s3_dual_ff;
   logic       s3_idx_ff, s3_idx_in;

   logic       s1_adv, s2_adv, s3_load;
   dec_type    out_dec;

   assign s3_load   = !s3_vld_ff || (rsp_ready && rsp_last);
   assign s2_adv    = !s2_vld_ff || s3_load;
   assign s1_adv    = !s1_vld_ff || s2_adv;
   assign req_ready = s1_adv;

   always_comb begin
      s1_vld_in = s1_adv ? (req_valid && req_slot0_valid) : s1_vld_ff;
      s2_vld_in = s2_adv ? s1_vld_ff : s2_vld_ff;
      s3_vld_in = s3_load ? s2_vld_ff : s3_vld_ff;
      if (s3_load) begin
         s3_idx_in = 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         s3_idx_in = 1'b1;
      end else begin
         s3_idx_in = s3_idx_ff;
      end
   end

   // a zero destination means no load in that lane
   always_comb begin
      s2_stall_in = 1'b0;
      if (s1_ld0_ff != 5'd0 && (reads_reg(s1_d0_ff, s1_ld0_ff) ||
          (s1_v1_ff && reads_reg(s1_d1_ff, s1_ld0_ff)))) begin
         s2_stall_in = 1'b1;
      end
      if (s1_ld1_ff != 5'd0 && (reads_reg(s1_d0_ff, s1_ld1_ff) ||
          (s1_v1_ff && reads_reg(s1_d1_ff, s1_ld1_ff)))) begin
         s2_stall_in = 1'b1;
      end
      s2_dual_in = s1_v1_ff && pairable(s1_d0_ff, s1_d1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s3_idx_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s3_idx_ff <= s3_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_d0_ff  <= decode_word(req_slot0_word);
         s1_d1_ff  <= decode_word(req_slot1_word);
         s1_v1_ff  <= req_slot1_valid;
         s1_ld0_ff <= req_ex_load_dest0;
         s1_ld1_ff <= req_ex_load_dest1;
      end
      if (s2_adv) begin
         s2_d0_ff    <= s1_d0_ff;
         s2_d1_ff    <= s1_d1_ff;
         s2_stall_ff <= s2_stall_in;
         s2_dual_ff  <= s2_dual_in;
      end
      if (s3_load) begin
         s3_d0_ff    <= s2_d0_ff;
         s3_d1_ff    <= s2_d1_ff;
         s3_stall_ff <= s2_stall_ff;
         s3_dual_ff  <= s2_dual_ff;
      end
   end

   always_comb begin
      out_dec = s3_idx_ff ? s3_d1_ff : s3_d0_ff;
      if (s3_stall_ff) begin
         out_dec = '0;
      end
   end

   assign rsp_valid      = s3_vld_ff;
   assign rsp_action     = s3_stall_ff ? ACT_STALL : (s3_dual_ff ? ACT_DUAL : ACT_SINGLE);
   assign rsp_lane       = s3_idx_ff;
   assign rsp_last       = s3_stall_ff || !s3_dual_ff || s3_idx_ff;
   assign rsp_dest_reg   = out_dec.rd;
   assign rsp_src1_reg   = out_dec.rs1;
   assign rsp_src2_reg   = out_dec.rs2;
   assign rsp_immediate  = $signed(out_dec.imm);
   assign rsp_func3      = out_dec.func3;
   assign rsp_writes_reg = out_dec.wr;
   assign rsp_mem_read   = out_dec.mem && out_dec.wr;
   assign rsp_mem_write  = out_dec.mem && !out_dec.wr;
   assign rsp_kind       = out_dec.kind;

endmodule

`default_nettype wire

FILE: rtl/core/rvdi_checker.sv
`default_nettype none

module rvdi_checker
   import rvdi_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_action,
   input wire logic       rsp_lane,
   input wire logic [4:0] rsp_dest_reg,
   input wire logic [4:0] rsp_kind,
   input wire logic       rsp_last
);

   // stalled output word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) && $stable(rsp_lane))
      else $error("output word changed while stalled");

   a_stall_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_STALL |->
         rsp_last && !rsp_lane && rsp_dest_reg == 5'd0 && rsp_kind == KIND_RTYPE)
      else $error("stall word not clean");

   a_lane1: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lane |-> rsp_action == ACT_DUAL && rsp_last)
      else $error("lane 1 word outside a dual issue");

   // first half of a dual issue is followed at once by its partner
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_action == ACT_DUAL && rsp_lane && rsp_last)
      else $error("dual issue partner missing");

   a_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action == ACT_STALL || rsp_action == ACT_SINGLE ||
                    rsp_action == ACT_DUAL)
      else $error("bad action code");

endmodule

bind rv32i_dual_issue_decode rvdi_checker u_rvdi_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_action   (rsp_action),
   .rsp_lane     (rsp_lane),
   .rsp_dest_reg (rsp_dest_reg),
   .rsp_kind     (rsp_kind),
   .rsp_last     (rsp_last)
);

`default_nettype wire

FILE: dv/rv32i_dual_issue_decode_test.sv
`timescale 1ns / 100ps

module rv32i_dual_issue_decode_test;
   import rvdi_pkg::*;

   localparam logic [2:0] F3_ADD    = 3'd0;
   localparam logic [2:0] F3_LW     = 3'd2;
   localparam logic [2:0] F3_SW     = 3'd2;
   localparam logic [2:0] F3_BNE    = 3'd1;
   localparam logic [2:0] F3_CSRRW  = 3'd1;
   localparam logic [2:0] F3_CSRRCI = 3'd7;
   localparam logic [6:0] F7_SUB    = 7'h20;

   localparam int unsigned RANDOM_PAIRS = 1650;
   localparam int unsigned HOLD_CYCLES  = 200;

   // field order matches the rsp_ port list
   typedef struct packed {
      logic [1:0]  action;
      logic        lane;
      logic [4:0]  dest_reg;
      logic [4:0]  src1_reg;
      logic [4:0]  src2_reg;
      logic [31:0] immediate;
      logic [2:0]  func3;
      logic        writes_reg;
      logic        mem_read;
      logic        mem_write;
      logic [4:0]  kind;
      logic        last;
   } issue_word_type;

   typedef struct packed {
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  f3;
      logic [31:0] imm;
      logic [4:0]  kind;
      logic        reads_rs1;
      logic        reads_rs2;
      logic        writes;
      logic        is_mem;
      logic        is_ctl;
   } instr_fields_type;

   class issue_predictor;
      issue_word_type pending_issues[$];
      int unsigned errors;
      int unsigned num_checked;

      function int unsigned pending();
         return pending_issues.size();
      endfunction

      function instr_fields_type crack(logic [31:0] w);
         instr_fields_type f;
         f = '0;
         f.rd  = w[11:7];
         f.rs1 = w[19:15];
         f.rs2 = w[24:20];
         f.f3  = w[14:12];
         case (w[6:0])
            OP_RTYPE: begin
               f.kind = KIND_RTYPE;
               f.reads_rs1 = 1'b1;
               f.reads_rs2 = 1'b1;
               f.writes = 1'b1;
            end
            OP_ALUIMM, OP_LOAD, OP_JALR: begin
               f.imm = {{20{w[31]}}, w[31:20]};
               f.reads_rs1 = 1'b1;
               f.writes = 1'b1;
               f.is_mem = (w[6:0] == OP_LOAD);
               f.is_ctl = (w[6:0] == OP_JALR);
               f.kind = (w[6:0] == OP_ALUIMM) ? KIND_ALUIMM :
                        (w[6:0] == OP_LOAD) ? KIND_LOAD : KIND_JALR;
            end
            OP_STORE: begin
               f.kind = KIND_STORE;
               f.imm = {{20{w[31]}}, w[31:25], w[11:7]};
               f.reads_rs1 = 1'b1;
               f.reads_rs2 = 1'b1;
               f.is_mem = 1'b1;
            end
            OP_BRANCH: begin
               f.kind = KIND_BRANCH;
               f.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
               f.reads_rs1 = 1'b1;
               f.reads_rs2 = 1'b1;
               f.is_ctl = 1'b1;
            end
            OP_LUI, OP_AUIPC: begin
               f.kind = (w[6:0] == OP_LUI) ? KIND_LUI : KIND_AUIPC;
               f.imm = {w[31:12], 12'h000};
               f.writes = 1'b1;
            end
            OP_JAL: begin
               f.kind = KIND_JAL;
               f.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
               f.writes = 1'b1;
               f.is_ctl = 1'b1;
            end
            OP_SYSTEM: begin
               if (f.f3 == F3_PRIV) begin
                  if (w[31:20] == F12_ECALL) f.kind = KIND_ECALL;
                  else if (w[31:20] == F12_MRET) f.kind = KIND_MRET;
                  else if (w[31:20] == F12_EBREAK) f.kind = KIND_EBREAK;
                  else if (w[31:20] == F12_WFI) f.kind = KIND_WFI;
                  else f.kind = KIND_ILLEGAL;
                  f.is_ctl = (f.kind == KIND_ECALL) || (f.kind == KIND_MRET);
               end else if (f.f3 == F3_RESERVED) begin
                  f.kind = KIND_ILLEGAL;
               end else begin
                  f.kind = KIND_CSR;
                  f.imm = {20'h00000, w[31:20]};
                  f.is_ctl = 1'b1;
                  f.writes = (f.rd != 5'd0);
                  // zimm forms have f3[2] set and read nothing
                  f.reads_rs1 = !f.f3[2];
               end
            end
            OP_FENCE: f.kind = KIND_FENCE;
            OP_ZERO:  f.kind = KIND_ZERO;
            default:  f.kind = KIND_ILLEGAL;
         endcase
         return f;
      endfunction

      function bit uses(instr_fields_type f, logic [4:0] r);
         return (f.reads_rs1 && f.rs1 == r) || (f.reads_rs2 && f.rs2 == r);
      endfunction

      function bit may_pair(instr_fields_type a, instr_fields_type b);
         if (a.is_ctl || b.is_ctl || (a.is_mem && b.is_mem)) return 1'b0;
         return !(a.is_mem && a.writes && a.rd != 5'd0 && uses(b, a.rd));
      endfunction

      function issue_word_type to_word(instr_fields_type f, logic [1:0] act, logic lane,
                                       logic last);
         issue_word_type e;
         e.action     = act;
         e.lane       = lane;
         e.dest_reg   = f.rd;
         e.src1_reg   = f.rs1;
         e.src2_reg   = f.rs2;
         e.immediate  = f.imm;
         e.func3      = f.f3;
         e.writes_reg = f.writes;
         e.mem_read   = f.is_mem && f.writes;
         e.mem_write  = f.is_mem && !f.writes;
         e.kind       = f.kind;
         e.last       = last;
         return e;
      endfunction

      function void note_pair(logic s0v, logic [31:0] w0, logic s1v, logic [31:0] w1,
                              logic [4:0] ld0, logic [4:0] ld1);
         instr_fields_type f0;
         instr_fields_type f1;
         issue_word_type   bubble;
         bit               hazard;
         if (!s0v) return;
         f0 = crack(w0);
         f1 = crack(w1);
         hazard = (ld0 != 5'd0 && (uses(f0, ld0) || (s1v && uses(f1, ld0)))) ||
                  (ld1 != 5'd0 && (uses(f0, ld1) || (s1v && uses(f1, ld1))));
         if (hazard) begin
            bubble = '0;
            bubble.action = ACT_STALL;
            bubble.last = 1'b1;
            pending_issues.push_back(bubble);
         end else if (s1v && may_pair(f0, f1)) begin
            pending_issues.push_back(to_word(f0, ACT_DUAL, 1'b0, 1'b0));
            pending_issues.push_back(to_word(f1, ACT_DUAL, 1'b1, 1'b1));
         end else begin
            pending_issues.push_back(to_word(f0, ACT_SINGLE, 1'b0, 1'b1));
         end
      endfunction

      task report(string what, logic [31:0] got_v, logic [31:0] want_v);
         errors++;
         if (errors <= 40)
            $display("%0t word %0d: %s got %h want %h", $time, num_checked, what,
                     got_v, want_v);
      endtask

      task check_word(issue_word_type got);
         issue_word_type want;
         num_checked++;
         if (pending_issues.size() == 0) begin
            report("unexpected word, kind", 32'(got.kind), '0);
            return;
         end
         want = pending_issues.pop_front();
         if (got.action !== want.action)
            report("action", 32'(got.action), 32'(want.action));
         if (got.lane !== want.lane)
            report("lane", 32'(got.lane), 32'(want.lane));
         if (got.dest_reg !== want.dest_reg)
            report("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
         if (got.src1_reg !== want.src1_reg)
            report("src1_reg", 32'(got.src1_reg), 32'(want.src1_reg));
         if (got.src2_reg !== want.src2_reg)
            report("src2_reg", 32'(got.src2_reg), 32'(want.src2_reg));
         if (got.immediate !== want.immediate)
            report("immediate", got.immediate, want.immediate);
         if (got.func3 !== want.func3)
            report("func3", 32'(got.func3), 32'(want.func3));
         if (got.writes_reg !== want.writes_reg)
            report("writes_reg", 32'(got.writes_reg), 32'(want.writes_reg));
         if (got.mem_read !== want.mem_read)
            report("mem_read", 32'(got.mem_read), 32'(want.mem_read));
         if (got.mem_write !== want.mem_write)
            report("mem_write", 32'(got.mem_write), 32'(want.mem_write));
         if (got.kind !== want.kind)
            report("kind", 32'(got.kind), 32'(want.kind));
         if (got.last !== want.last)
            report("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic        req_slot0_valid;
   logic [31:0] req_slot0_word;
   logic        req_slot1_valid;
   logic [31:0] req_slot1_word;
   logic [4:0]  req_ex_load_dest0;
   logic [4:0]  req_ex_load_dest1;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_action;
   logic        rsp_lane;
   logic [4:0]  rsp_dest_reg;
   logic [4:0]  rsp_src1_reg;
   logic [4:0]  rsp_src2_reg;
   logic signed [31:0] rsp_immediate;
   logic [2:0]  rsp_func3;
   logic        rsp_writes_reg;
   logic        rsp_mem_read;
   logic        rsp_mem_write;
   logic [4:0]  rsp_kind;
   logic        rsp_last;

   issue_predictor sb;

   rv32i_dual_issue_decode u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_slot0_valid   (req_slot0_valid),
      .req_slot0_word    (req_slot0_word),
      .req_slot1_valid   (req_slot1_valid),
      .req_slot1_word    (req_slot1_word),
      .req_ex_load_dest0 (req_ex_load_dest0),
      .req_ex_load_dest1 (req_ex_load_dest1),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_lane          (rsp_lane),
      .rsp_dest_reg      (rsp_dest_reg),
      .rsp_src1_reg      (rsp_src1_reg),
      .rsp_src2_reg      (rsp_src2_reg),
      .rsp_immediate     (rsp_immediate),
      .rsp_func3         (rsp_func3),
      .rsp_writes_reg    (rsp_writes_reg),
      .rsp_mem_read      (rsp_mem_read),
      .rsp_mem_write     (rsp_mem_write),
      .rsp_kind          (rsp_kind),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // low registers are favored so load hazards and load-use pairs show up often
   function automatic logic [4:0] pick_reg();
      logic [4:0] r;
      r = ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      return r;
   endfunction

   function automatic logic [31:0] make_instr(int unsigned pick);
      logic [31:0] w;
      w = $urandom();
      if (pick > 16) return w;
      w[11:7]  = pick_reg();
      w[19:15] = pick_reg();
      if (pick < 9 || pick > 14) w[24:20] = pick_reg();
      case (pick)
         0: w[6:0] = OP_RTYPE;
         1: w[6:0] = OP_ALUIMM;
         2: w[6:0] = OP_LOAD;
         3: w[6:0] = OP_STORE;
         4: w[6:0] = OP_BRANCH;
         5: w[6:0] = OP_LUI;
         6: w[6:0] = OP_AUIPC;
         7: w[6:0] = OP_JAL;
         8: w[6:0] = OP_JALR;
         9: w = {F12_ECALL, w[19:15], F3_PRIV, w[11:7], OP_SYSTEM};
         10: w = {F12_MRET, w[19:15], F3_PRIV, w[11:7], OP_SYSTEM};
         11: w = {F12_EBREAK, w[19:15], F3_PRIV, w[11:7], OP_SYSTEM};
         12: w = {F12_WFI, w[19:15], F3_PRIV, w[11:7], OP_SYSTEM};
         13: begin
            w[6:0] = OP_SYSTEM;
            if (w[13:12] == 2'b00) w[12] = 1'b1;
         end
         14: begin
            w[6:0] = OP_SYSTEM;
            w[14:12] = w[31] ? F3_RESERVED : F3_PRIV;
         end
         15: w[6:0] = OP_FENCE;
         default: w[6:0] = OP_ZERO;
      endcase
      return w;
   endfunction

   task automatic send_pair(input logic s0v, input logic [31:0] w0, input logic s1v,
                            input logic [31:0] w1, input logic [4:0] ld0,
                            input logic [4:0] ld1);
      req_valid         <= 1'b1;
      req_slot0_valid   <= s0v;
      req_slot0_word    <= w0;
      req_slot1_valid   <= s1v;
      req_slot1_word    <= w1;
      req_ex_load_dest0 <= ld0;
      req_ex_load_dest1 <= ld1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pair(s0v, w0, s1v, w1, ld0, ld1);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid      <= 1'b0;
         req_slot0_word <= $urandom();
         req_slot1_word <= $urandom();
         repeat (cycles) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word({rsp_action, rsp_lane, rsp_dest_reg, rsp_src1_reg, rsp_src2_reg,
                        rsp_immediate, rsp_func3, rsp_writes_reg, rsp_mem_read,
                        rsp_mem_write, rsp_kind, rsp_last});
   end

   // result side: random ready pattern plus two long hold-offs
   initial begin
      int unsigned burst;
      int unsigned gap;
      bit          calm;
      bit          held_early;
      bit          held_late;
      calm = 1'b0;
      held_early = 1'b0;
      held_late = 1'b0;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ((!held_early && sb.num_checked >= 300) ||
             (!held_late && sb.num_checked >= 1500)) begin
            if (held_early) held_late = 1'b1;
            else held_early = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         burst = calm ? 40 : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (burst) @(posedge clock);
         gap = calm ? 0 : draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         calm = ($urandom_range(0, 9) == 0);
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL rv32i_dual_issue_decode");
      $finish;
   end

   initial begin
      logic        s0v;
      logic        s1v;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [4:0]  ld0;
      logic [4:0]  ld1;
      bit          calm;
      sb = new();
      req_valid = 1'b0;
      req_slot0_valid = 1'b0;
      req_slot0_word = '0;
      req_slot1_valid = 1'b0;
      req_slot1_word = '0;
      req_ex_load_dest0 = '0;
      req_ex_load_dest1 = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // slot 0 empty: no word comes back
      send_pair(1'b0, $urandom(), 1'b1, $urandom(), 5'd3, 5'd7);
      send_pair(1'b1, 32'h0000_0000, 1'b0, 32'h0000_0000, 5'd0, 5'd0);
      send_pair(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd31, 5'd31);
      // ALU result feeding partner still pairs
      send_pair(1'b1, {12'hFFF, 5'd0, F3_ADD, 5'd5, OP_ALUIMM}, 1'b1,
                {F7_SUB, 5'd5, 5'd5, F3_ADD, 5'd6, OP_RTYPE}, 5'd0, 5'd0);
      // load feeding partner
      send_pair(1'b1, {12'h7FF, 5'd1, F3_LW, 5'd7, OP_LOAD}, 1'b1,
                {7'h00, 5'd7, 5'd2, F3_ADD, 5'd8, OP_RTYPE}, 5'd0, 5'd0);
      // load to x0 does not block a reader of x0
      send_pair(1'b1, {12'h800, 5'd1, F3_LW, 5'd0, OP_LOAD}, 1'b1,
                {7'h00, 5'd0, 5'd0, F3_ADD, 5'd8, OP_RTYPE}, 5'd0, 5'd0);
      // two memory ops
      send_pair(1'b1, {12'h004, 5'd1, F3_LW, 5'd9, OP_LOAD}, 1'b1,
                {7'h40, 5'd10, 5'd11, F3_SW, 5'h1F, OP_STORE}, 5'd0, 5'd0);
      send_pair(1'b1, {1'b1, 6'h3F, 5'd2, 5'd1, F3_BNE, 4'hF, 1'b1, OP_BRANCH}, 1'b1,
                {12'h001, 5'd1, F3_ADD, 5'd1, OP_ALUIMM}, 5'd0, 5'd0);
      send_pair(1'b1, {1'b0, 6'h00, 5'd2, 5'd1, F3_BNE, 4'h1, 1'b0, OP_BRANCH}, 1'b0,
                32'h0, 5'd0, 5'd0);
      send_pair(1'b1, {12'h001, 5'd1, F3_ADD, 5'd1, OP_ALUIMM}, 1'b1,
                {1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd1, OP_JAL}, 5'd0, 5'd0);
      send_pair(1'b1, {1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OP_JAL}, 1'b1,
                {12'h800, 5'd1, F3_ADD, 5'd0, OP_JALR}, 5'd0, 5'd0);
      send_pair(1'b1, {20'hFFFFF, 5'd4, OP_LUI}, 1'b1, {20'h80000, 5'd5, OP_AUIPC},
                5'd0, 5'd0);
      send_pair(1'b1, {F12_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM}, 1'b1,
                {12'h001, 5'd1, F3_ADD, 5'd1, OP_ALUIMM}, 5'd0, 5'd0);
      send_pair(1'b1, {F12_MRET, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM}, 1'b1,
                {F12_WFI, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM}, 5'd0, 5'd0);
      send_pair(1'b1, {F12_EBREAK, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM}, 1'b1,
                {F12_WFI, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM}, 5'd0, 5'd0);
      send_pair(1'b1, {12'hFFF, 5'd2, F3_CSRRW, 5'd1, OP_SYSTEM}, 1'b1,
                {12'h001, 5'd1, F3_ADD, 5'd1, OP_ALUIMM}, 5'd0, 5'd0);
      // zimm equal to a load dest reads nothing, so no stall
      send_pair(1'b1, {12'h305, 5'd31, F3_CSRRCI, 5'd0, OP_SYSTEM}, 1'b0, 32'h0,
                5'd31, 5'd0);
      send_pair(1'b1, {12'h000, 5'd3, F3_RESERVED, 5'd2, OP_SYSTEM}, 1'b1,
                {4'h0, 4'hF, 4'hF, 5'd0, 3'd0, 5'd0, OP_FENCE}, 5'd0, 5'd0);
      send_pair(1'b1, {12'h7FF, 5'd3, F3_PRIV, 5'd2, OP_SYSTEM}, 1'b1,
                {25'h1FF_FFFF, OP_ZERO}, 5'd0, 5'd0);
      // load in execute hazards
      send_pair(1'b1, {7'h00, 5'd2, 5'd3, F3_ADD, 5'd1, OP_RTYPE}, 1'b0, 32'h0,
                5'd3, 5'd0);
      send_pair(1'b1, {12'h001, 5'd0, F3_ADD, 5'd0, OP_ALUIMM}, 1'b1,
                {7'h00, 5'd4, 5'd1, F3_ADD, 5'd1, OP_RTYPE}, 5'd0, 5'd4);
      send_pair(1'b1, {12'h001, 5'd0, F3_ADD, 5'd0, OP_ALUIMM}, 1'b0,
                {7'h00, 5'd4, 5'd1, F3_ADD, 5'd1, OP_RTYPE}, 5'd0, 5'd4);
      send_pair(1'b1, {7'h00, 5'd0, 5'd0, F3_ADD, 5'd1, OP_RTYPE}, 1'b1,
                {7'h00, 5'd0, 5'd0, F3_ADD, 5'd2, OP_RTYPE}, 5'd0, 5'd0);
      send_pair(1'b1, {12'h340, 5'd6, F3_CSRRW, 5'd6, OP_SYSTEM}, 1'b0, 32'h0,
                5'd0, 5'd6);
      send_pair(1'b1, {7'h00, 5'd12, 5'd1, F3_SW, 5'd0, OP_STORE}, 1'b0, 32'h0,
                5'd12, 5'd9);

      calm = 1'b0;
      for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
         if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_PAIRS / 2) begin
            // let the pipe drain completely before carrying on
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         s0v = ($urandom_range(0, 11) != 0);
         s1v = ($urandom_range(0, 6) != 0);
         w0  = make_instr(($urandom_range(0, 7) == 0) ? 17 : $urandom_range(0, 16));
         w1  = make_instr(($urandom_range(0, 7) == 0) ? 17 : $urandom_range(0, 16));
         ld0 = ($urandom_range(0, 9) < 4) ? 5'd0 : pick_reg();
         ld1 = ($urandom_range(0, 9) < 4) ? 5'd0 : pick_reg();
         send_pair(s0v, w0, s1v, w1, ld0, ld1);
         idle_sender(calm ? 0 : draw_gap());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS rv32i_dual_issue_decode");
      else
         $display("FAIL rv32i_dual_issue_decode");
      $finish;
   end

endmodule

FILE: rv32i_dual_issue_decode.f
rtl/core/rvdi_pkg.sv
rtl/core/rv32i_dual_issue_decode.sv
rtl/core/rvdi_checker.sv
dv/rv32i_dual_issue_decode_test.sv
